// ===== hdl/klx_pkg.sv =====
// ----------------------------------------------------------------------------
// klx_pkg: shared types and constants of the lexer
// Holds the request and token structs, token kinds, character classes and the
// keyword spelling table.
// ----------------------------------------------------------------------------
package klx_pkg;

    // one input request: a character or an end-of-input mark
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    // one token
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  token_char;
        logic [7:0]  ident_length;
        logic [31:0] num_mantissa;
        logic [7:0]  num_frac_digits;
        logic        num_overflow;
        logic        last_of_run;
    } t_out_item;

    // tokens produced by one request, first one goes out first
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_step_out;

    // token kinds
    localparam logic [2:0] KIND_EOF    = 3'd0;
    localparam logic [2:0] KIND_DEF    = 3'd1;
    localparam logic [2:0] KIND_EXTERN = 3'd2;
    localparam logic [2:0] KIND_RETURN = 3'd3;
    localparam logic [2:0] KIND_IDENT  = 3'd4;
    localparam logic [2:0] KIND_NUMBER = 3'd5;
    localparam logic [2:0] KIND_CHAR   = 3'd6;

    // special characters
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    // keyword lengths
    localparam logic [7:0] KW_DEF_LEN    = 8'd3;
    localparam logic [7:0] KW_EXTERN_LEN = 8'd6;
    localparam logic [7:0] KW_RETURN_LEN = 8'd6;

    // output queue
    localparam int FIFO_DEPTH = 4;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // true when character c is letter idx of keyword k (0 def, 1 extern, 2 return)
    function automatic logic kw_match(input logic [1:0] k, input logic [7:0] idx,
                                      input logic [7:0] c);
        logic [47:0] text;
        logic [7:0]  len;
        logic [7:0]  exp_ch;
        text = 48'h0;
        len  = 8'd0;
        unique case (k)
            2'd0: begin
                text = {24'h0, "fed"};
                len  = KW_DEF_LEN;
            end
            2'd1: begin
                text = "nretxe";
                len  = KW_EXTERN_LEN;
            end
            2'd2: begin
                text = "nruter";
                len  = KW_RETURN_LEN;
            end
            default: begin
                text = 48'h0;
                len  = 8'd0;
            end
        endcase
        exp_ch = text[8*idx[2:0] +: 8];
        return (idx < len) && (exp_ch == c);
    endfunction

endpackage

// ===== hdl/klx_core.sv =====
// ----------------------------------------------------------------------------
// klx_core: scanner state and per-character step
// Keeps the scan state of the token in progress and works out, for the
// request in the input register, the next state and up to two tokens.
// ----------------------------------------------------------------------------
module klx_core
    import klx_pkg::*;
#(
    parameter int MANTISSA_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_step_out o_step
);

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_NUMBER  = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    logic [1:0]               r_mode,  n_mode;
    logic [2:0]               r_alive, n_alive;
    logic [7:0]               r_len,   n_len;
    logic [MANTISSA_BITS-1:0] r_acc,   n_acc;
    logic [7:0]               r_frac,  n_frac;
    logic                     r_dot,   n_dot;
    logic                     r_stop,  n_stop;
    logic                     r_sat,   n_sat;

    logic [7:0] w_c;
    logic       w_eoi;
    logic       w_word_go;
    logic       w_num_go;

    assign w_c   = i_item.char_code;
    assign w_eoi = i_item.end_of_input;

    // character continues the current token
    assign w_word_go = (r_mode == MODE_WORD) && (is_alpha(w_c) || is_digit(w_c));
    assign w_num_go  = (r_mode == MODE_NUMBER) && (is_digit(w_c) || w_c == CH_DOT);

    // word extension, from the running word or from a fresh one
    logic [2:0] w_wb_alive, wx_alive;
    logic [7:0] w_wb_len,   wx_len;

    assign w_wb_alive = w_word_go ? r_alive : 3'b111;
    assign w_wb_len   = w_word_go ? r_len : 8'd0;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wx_alive[k] = w_wb_alive[k] && kw_match(2'(k), w_wb_len, w_c);
        end
        wx_len = (w_wb_len == 8'hFF) ? w_wb_len : w_wb_len + 8'd1;
    end

    // number extension, from the running number or from a fresh one
    logic [MANTISSA_BITS-1:0] w_nb_acc, nx_acc;
    logic [7:0]               w_nb_frac, nx_frac;
    logic                     w_nb_dot, w_nb_stop, w_nb_sat;
    logic                     nx_dot, nx_stop, nx_sat;
    logic [MANTISSA_BITS+3:0] w_prod;

    assign w_nb_acc  = w_num_go ? r_acc : '0;
    assign w_nb_frac = w_num_go ? r_frac : 8'd0;
    assign w_nb_dot  = w_num_go ? r_dot : 1'b0;
    assign w_nb_stop = w_num_go ? r_stop : 1'b0;
    assign w_nb_sat  = w_num_go ? r_sat : 1'b0;

    // acc * 10 + digit, by shifts
    assign w_prod = {w_nb_acc, 3'b000} + {2'b00, w_nb_acc, 1'b0}
                  + (MANTISSA_BITS+4)'(w_c[3:0]);

    always_comb begin
        nx_acc  = w_nb_acc;
        nx_frac = w_nb_frac;
        nx_dot  = w_nb_dot;
        nx_stop = w_nb_stop;
        nx_sat  = w_nb_sat;
        if (!w_nb_stop) begin
            if (w_c == CH_DOT) begin
                if (w_nb_dot) begin
                    nx_stop = 1'b1;
                end else begin
                    nx_dot = 1'b1;
                end
            end else begin
                if (w_prod[MANTISSA_BITS+3:MANTISSA_BITS] != 4'd0) begin
                    nx_acc = '1;
                    nx_sat = 1'b1;
                end else begin
                    nx_acc = w_prod[MANTISSA_BITS-1:0];
                end
                if (w_nb_dot && w_nb_frac != 8'hFF) begin
                    nx_frac = w_nb_frac + 8'd1;
                end
            end
        end
    end

    // token emitted when the running word or number ends
    logic [MANTISSA_BITS+31:0] w_acc_ext;
    t_out_item                 w_flush_item;
    logic                      w_flush_avail;

    assign w_acc_ext     = {32'd0, r_acc};
    assign w_flush_avail = (r_mode == MODE_WORD) || (r_mode == MODE_NUMBER);

    always_comb begin
        w_flush_item = '0;
        if (r_mode == MODE_WORD) begin
            w_flush_item.token_kind = KIND_IDENT;
            if (r_alive[0] && r_len == KW_DEF_LEN) begin
                w_flush_item.token_kind = KIND_DEF;
            end
            if (r_alive[1] && r_len == KW_EXTERN_LEN) begin
                w_flush_item.token_kind = KIND_EXTERN;
            end
            if (r_alive[2] && r_len == KW_RETURN_LEN) begin
                w_flush_item.token_kind = KIND_RETURN;
            end
            w_flush_item.ident_length = r_len;
        end else begin
            w_flush_item.token_kind      = KIND_NUMBER;
            w_flush_item.num_mantissa    = w_acc_ext[31:0];
            w_flush_item.num_frac_digits = r_frac;
            w_flush_item.num_overflow    = r_sat;
        end
    end

    // step decision
    logic      w_flush_en;
    logic      w_sec_valid;
    logic      w_flush_valid;
    t_out_item w_sec_item;

    always_comb begin
        n_mode      = r_mode;
        n_alive     = r_alive;
        n_len       = r_len;
        n_acc       = r_acc;
        n_frac      = r_frac;
        n_dot       = r_dot;
        n_stop      = r_stop;
        n_sat       = r_sat;
        w_flush_en  = 1'b0;
        w_sec_valid = 1'b0;
        w_sec_item  = '0;
        if (w_eoi) begin
            // end of stream: flush, then eof
            w_flush_en            = 1'b1;
            w_sec_valid           = 1'b1;
            w_sec_item.token_kind = KIND_EOF;
            n_mode  = MODE_IDLE;
            n_alive = 3'b000;
            n_len   = 8'd0;
            n_acc   = '0;
            n_frac  = 8'd0;
            n_dot   = 1'b0;
            n_stop  = 1'b0;
            n_sat   = 1'b0;
        end else if (r_mode == MODE_COMMENT) begin
            if (w_c == CH_LF || w_c == CH_CR) begin
                n_mode = MODE_IDLE;
            end
        end else if (w_word_go) begin
            n_alive = wx_alive;
            n_len   = wx_len;
        end else if (w_num_go) begin
            n_acc  = nx_acc;
            n_frac = nx_frac;
            n_dot  = nx_dot;
            n_stop = nx_stop;
            n_sat  = nx_sat;
        end else begin
            // token boundary: flush, clear, then handle the character as new
            w_flush_en = 1'b1;
            n_mode  = MODE_IDLE;
            n_alive = 3'b000;
            n_len   = 8'd0;
            n_acc   = '0;
            n_frac  = 8'd0;
            n_dot   = 1'b0;
            n_stop  = 1'b0;
            n_sat   = 1'b0;
            priority if (is_space(w_c)) begin
                n_mode = MODE_IDLE;
            end else if (is_alpha(w_c)) begin
                n_mode  = MODE_WORD;
                n_alive = wx_alive;
                n_len   = wx_len;
            end else if (is_digit(w_c) || w_c == CH_DOT) begin
                n_mode = MODE_NUMBER;
                n_acc  = nx_acc;
                n_frac = nx_frac;
                n_dot  = nx_dot;
                n_stop = nx_stop;
                n_sat  = nx_sat;
            end else if (w_c == CH_HASH) begin
                n_mode = MODE_COMMENT;
            end else begin
                w_sec_valid           = 1'b1;
                w_sec_item.token_kind = KIND_CHAR;
                w_sec_item.token_char = w_c;
            end
        end
    end

    // pack the tokens of this request
    assign w_flush_valid = w_flush_en && w_flush_avail;

    always_comb begin
        o_step.count  = {1'b0, w_flush_valid} + {1'b0, w_sec_valid};
        o_step.first  = w_flush_valid ? w_flush_item : w_sec_item;
        o_step.second = w_sec_item;
        o_step.first.last_of_run  = (o_step.count == 2'd1);
        o_step.second.last_of_run = 1'b1;
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_alive <= 3'b000;
            r_len   <= 8'd0;
            r_acc   <= '0;
            r_frac  <= 8'd0;
            r_dot   <= 1'b0;
            r_stop  <= 1'b0;
            r_sat   <= 1'b0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_alive <= n_alive;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_frac  <= n_frac;
            r_dot   <= n_dot;
            r_stop  <= n_stop;
            r_sat   <= n_sat;
        end
    end

    // end of stream always leaves the scanner idle
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_eoi) |=> (r_mode == MODE_IDLE))
        else $error("scanner not idle after end of input");

    // no token fields carried outside a word or number
    a_clear_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE || r_mode == MODE_COMMENT) |-> (r_len == 8'd0 && r_acc == '0))
        else $error("token state left over between tokens");

    // two tokens only at a boundary that flushes a word or number
    a_two_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_step.count == 2'd2) |-> (w_flush_avail && !o_step.first.last_of_run))
        else $error("second token without a flushed token");

endmodule

// ===== hdl/klx_out_fifo.sv =====
// ----------------------------------------------------------------------------
// klx_out_fifo: token output queue
// Small register queue that takes up to two tokens per cycle when it has room
// and hands them out one per cycle on a valid/ready channel when ready.
// ----------------------------------------------------------------------------
module klx_out_fifo
    import klx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_step_out i_step,
    output logic      o_space2,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_out_item        r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       w_wn;
    logic             w_pop;
    logic [PTR_W-1:0] w_wr1;

    assign w_wn   = i_push ? i_step.count : 2'd0;
    assign w_pop  = o_valid && i_ready;
    assign w_wr1  = r_wr + PTR_W'(1);

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd];
    assign o_space2 = (r_count <= CNT_W'(FIFO_DEPTH - 2));

    // pointers and fill level
    always_comb begin
        n_wr    = r_wr + PTR_W'(w_wn);
        n_rd    = r_rd + PTR_W'(w_pop);
        n_count = r_count + CNT_W'(w_wn) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (w_wn != 2'd0) begin
            r_mem[r_wr] <= i_step.first;
        end
        if (w_wn == 2'd2) begin
            r_mem[w_wr1] <= i_step.second;
        end
    end

    // fill level never passes the depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("token queue overflow");

    // a push only happens with room for two tokens
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wn != 2'd0) |-> o_space2)
        else $error("push without room");

    // pointers stay apart by the fill level
    a_ptr_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == PTR_W'(r_count))
        else $error("queue pointers disagree with fill level");

endmodule

// ===== hdl/keyword_identifier_number_lexer_top.sv =====
// ----------------------------------------------------------------------------
// keyword_identifier_number_lexer_top: streaming character lexer
// Turns a character stream into tokens: keywords def/extern/return,
// identifiers with their length, numbers as mantissa plus fraction digits,
// single-character tokens and end of input. Comments and whitespace skipped.
//
//   channel  direction  handshake                     payload
//   in       in         i_in_valid / o_in_ready       i_in_data  (t_in_item)
//   out      out        o_out_valid / i_out_ready     o_out_data (t_out_item)
//
// One character request per cycle while the queue has room: input register,
// one step of scan logic, then a four-entry token queue that the scanner
// writes directly. A request yields zero, one or two tokens; the queue drains
// one per cycle while the output is ready.
// A token passes through the input register and the queue before it leaves.
// Synchronous active-low reset clears the scanner to idle and empties the queue.
// The input register advances only while the queue holds two tokens or fewer;
// under an output stall o_in_ready falls once three or more are queued and a
// request waits, and rises the cycle after pops bring the queue back to two.
// ----------------------------------------------------------------------------
module keyword_identifier_number_lexer_top
    import klx_pkg::*;
#(
    parameter int MANTISSA_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in;
    logic      w_space2;
    logic      w_advance;
    logic      w_load;
    t_step_out w_step;

    // input register moves into the scanner when the queue has room
    assign w_advance  = r_in_valid && w_space2;
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_load     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_load) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in <= i_in_data;
        end
    end

    // scanner
    klx_core #(
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in),
        .o_step    (w_step)
    );

    // token queue
    klx_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_advance),
        .i_step   (w_step),
        .o_space2 (w_space2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

endmodule
